FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL queue and back-end files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Types and constants shared by the run-length row encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  localparam int unsigned CFG_W = 13;
  localparam int unsigned SYM_W = 8;
  localparam logic [CFG_W-1:0] ROW_LENGTH_RESET = 13'd64;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NL   = 8'd10;

  // Division by ten as a multiply by a scaled reciprocal; exact for inputs
  // below 2^18, which covers every run count.
  localparam int unsigned     DIV10_SHIFT  = 20;
  localparam int unsigned     DIV10_PROD_W = 40;
  localparam logic [16:0]     DIV10_MUL    = 17'd104858;

  localparam int unsigned MAX_DIGITS = 5;
  localparam int unsigned DIG_IDX_W  = 3;

  typedef struct packed {
    logic has_a;
    logic has_b;
  } cmd_flags_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_DIGIT,
    B_SYM,
    B_NL
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/rle_front.sv
// ----------------------------------------------------------------------------
// rle_front
// Accepts cells, tracks run and column, and queues run emit commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_front #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned NW       = 13,
  parameter int unsigned CW       = 12,
  parameter int unsigned FW       = 44
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cell_valid,
  output logic                              cell_stall,
  input  wire logic [7:0]                   cell_value,
  input  wire logic                         cfg_valid,
  input  wire logic [rle_pkg::CFG_W-1:0]    cfg_data,
  output logic                              push,
  output logic [FW-1:0]                     push_data,
  input  wire logic                         fifo_full
);

  localparam int unsigned CMP_W = 18;

  logic [rle_pkg::CFG_W-1:0] row_len;
  logic [rle_pkg::SYM_W-1:0] run_symbol;
  logic [NW-1:0]             run_count;
  logic [CW-1:0]             column;

  logic [CMP_W-1:0]          len_eff;
  logic                      accept;
  logic                      first;
  logic                      flush_a;
  logic                      eol;
  logic [rle_pkg::SYM_W-1:0] new_sym;
  logic [NW-1:0]             new_cnt;
  rle_pkg::cmd_flags_t       flags;

  always_comb begin
    if (row_len == '0) begin
      len_eff = CMP_W'(1);
    end else if (CMP_W'(row_len) > CMP_W'(MAX_COLS)) begin
      len_eff = CMP_W'(MAX_COLS);
    end else begin
      len_eff = CMP_W'(row_len);
    end
  end

  assign cell_stall = fifo_full;
  assign accept     = cell_valid && !fifo_full;
  assign first      = (column == '0);
  assign flush_a    = !first && (cell_value != run_symbol);
  assign eol        = (CMP_W'(column) + CMP_W'(1)) >= len_eff;
  assign new_sym    = (first || flush_a) ? cell_value : run_symbol;
  assign new_cnt    = (first || flush_a) ? NW'(1) : run_count + NW'(1);

  assign flags.has_a = flush_a;
  assign flags.has_b = eol;
  assign push        = accept && (flush_a || eol);
  assign push_data   = {flags, run_count, run_symbol, new_cnt, new_sym};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len    <= rle_pkg::ROW_LENGTH_RESET;
      run_symbol <= '0;
      run_count  <= '0;
      column     <= '0;
    end else begin
      if (cfg_valid) begin
        row_len <= cfg_data;
      end
      if (accept) begin
        if (eol) begin
          run_symbol <= '0;
          run_count  <= '0;
          column     <= '0;
        end else begin
          run_symbol <= new_sym;
          run_count  <= new_cnt;
          column     <= column + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rle_cmd_fifo
// Short register queue of emit commands between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rle_cmd_fifo #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full     = (count == NW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && full), "command queue overflow")
  `ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && empty), "command queue underflow")

endmodule

`default_nettype wire

FILE: rtl/rle_back.sv
// ----------------------------------------------------------------------------
// rle_back
// Turns queued run commands into decimal digits, symbols and newlines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rle_back #(
  parameter int unsigned NW = 13,
  parameter int unsigned FW = 44
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fifo_empty,
  input  wire logic [FW-1:0] fifo_data,
  output logic               pop,
  output logic               char_valid,
  input  wire logic          char_stall,
  output logic [7:0]         out_char,
  output logic               last_of_burst
);

  localparam int unsigned RW = NW + rle_pkg::SYM_W;

  rle_pkg::back_state_t state;
  rle_pkg::back_state_t state_next;

  rle_pkg::cmd_flags_t       flags;
  logic [NW-1:0]             cnt_b;
  logic [rle_pkg::SYM_W-1:0] sym_a;
  logic [rle_pkg::SYM_W-1:0] sym_b;
  logic                      phase_b;
  logic [NW-1:0]             conv;
  logic [3:0]                digits [rle_pkg::MAX_DIGITS];
  logic [rle_pkg::DIG_IDX_W-1:0] ndig;
  logic [rle_pkg::DIG_IDX_W-1:0] idx;

  rle_pkg::cmd_flags_t       in_flags;
  logic [NW-1:0]             in_cnt_a;
  logic [rle_pkg::SYM_W-1:0] in_sym_a;
  logic [NW-1:0]             in_cnt_b;
  logic [rle_pkg::SYM_W-1:0] in_sym_b;

  logic [rle_pkg::DIV10_PROD_W-1:0] prod;
  logic [NW-1:0]             quo;
  logic [NW-1:0]             quo10;
  logic [3:0]                rem;

  logic                      out_free;
  logic                      emit;
  logic [7:0]                char_d;
  logic                      last_d;

  assign in_flags = rle_pkg::cmd_flags_t'(fifo_data[FW-1 -: 2]);
  assign in_cnt_a = fifo_data[2*RW-1 -: NW];
  assign in_sym_a = fifo_data[RW+rle_pkg::SYM_W-1 -: rle_pkg::SYM_W];
  assign in_cnt_b = fifo_data[RW-1 -: NW];
  assign in_sym_b = fifo_data[rle_pkg::SYM_W-1:0];

  // One decimal digit per cycle, least significant first.
  assign prod  = rle_pkg::DIV10_PROD_W'(conv)
               * rle_pkg::DIV10_PROD_W'(rle_pkg::DIV10_MUL);
  assign quo   = prod[rle_pkg::DIV10_SHIFT +: NW];
  assign quo10 = NW'({quo, 3'b000}) + NW'({quo, 1'b0});
  assign rem   = 4'(conv - quo10);

  assign out_free = !char_valid || !char_stall;

  always_comb begin
    state_next = state;
    case (state)
      rle_pkg::B_IDLE: begin
        if (!fifo_empty) begin
          state_next = rle_pkg::B_CONV;
        end
      end
      rle_pkg::B_CONV: begin
        if (quo == '0) begin
          state_next = rle_pkg::B_DIGIT;
        end
      end
      rle_pkg::B_DIGIT: begin
        if (out_free && idx == '0) begin
          state_next = rle_pkg::B_SYM;
        end
      end
      rle_pkg::B_SYM: begin
        if (out_free) begin
          if (phase_b) begin
            state_next = rle_pkg::B_NL;
          end else if (flags.has_b) begin
            state_next = rle_pkg::B_CONV;
          end else begin
            state_next = rle_pkg::B_IDLE;
          end
        end
      end
      rle_pkg::B_NL: begin
        if (out_free) begin
          state_next = rle_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = rle_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    emit   = 1'b0;
    char_d = rle_pkg::ASCII_NL;
    last_d = 1'b0;
    case (state)
      rle_pkg::B_IDLE: begin
        pop = !fifo_empty;
      end
      rle_pkg::B_DIGIT: begin
        emit   = out_free;
        char_d = rle_pkg::ASCII_ZERO + {4'b0000, digits[idx]};
      end
      rle_pkg::B_SYM: begin
        emit   = out_free;
        char_d = phase_b ? sym_b : sym_a;
        last_d = !phase_b && !flags.has_b;
      end
      rle_pkg::B_NL: begin
        emit   = out_free;
        char_d = rle_pkg::ASCII_NL;
        last_d = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rle_pkg::B_IDLE;
      char_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char      <= char_d;
      last_of_burst <= last_d;
    end
    case (state)
      rle_pkg::B_IDLE: begin
        if (pop) begin
          flags   <= in_flags;
          sym_a   <= in_sym_a;
          cnt_b   <= in_cnt_b;
          sym_b   <= in_sym_b;
          phase_b <= !in_flags.has_a;
          conv    <= in_flags.has_a ? in_cnt_a : in_cnt_b;
          ndig    <= '0;
        end
      end
      rle_pkg::B_CONV: begin
        digits[ndig] <= rem;
        ndig         <= ndig + rle_pkg::DIG_IDX_W'(1);
        idx          <= ndig;
        conv         <= quo;
      end
      rle_pkg::B_DIGIT: begin
        if (out_free) begin
          idx <= idx - rle_pkg::DIG_IDX_W'(1);
        end
      end
      rle_pkg::B_SYM: begin
        if (out_free && !phase_b && flags.has_b) begin
          phase_b <= 1'b1;
          conv    <= cnt_b;
          ndig    <= '0;
        end
      end
      default: begin
        conv <= conv;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_digit_idx, clk, rst, state == rle_pkg::B_DIGIT, idx < ndig, "digit index out of range")
  `ASSERT_IMPLIES(a_nl_phase, clk, rst, state == rle_pkg::B_NL, phase_b, "newline outside end-of-row run")

endmodule

`default_nettype wire

FILE: rtl/rle_row_encoder.sv
// ----------------------------------------------------------------------------
// rle_row_encoder
// Run-length encoder for rows of cell characters, emitting ASCII text.
// ----------------------------------------------------------------------------
// Cells enter on cell_valid / cell_stall with cell_value, row-major order.
// Characters leave on char_valid / char_stall with out_char and last_of_burst,
// which marks the final character caused by one cell. row_length is written
// on cfg_valid / cfg_ready (always ready). The user must write it only while
// nothing is in flight; the block itself does not enforce this. A cell that
// ends no run produces nothing. A cell that produces output is queued as a
// command; the back end takes it, then per run converts the count one decimal
// digit per cycle, sends the digits and then the symbol, and sends a newline
// at the end of a row; a cell that ends a row and also closes a run sends both
// runs. The first character of a cell passes through the command queue, the
// converter and the output register.
// Synchronous rst clears the run state, the command queue and the output
// valid flag, and sets row_length to 64. A stalled output holds its character;
// the back end waits, the command queue fills and cell_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_row_encoder #(
  parameter int unsigned MAX_COLS   = 4096,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cell_valid,
  output logic                           cell_stall,
  input  wire logic [7:0]                cell_value,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rle_pkg::CFG_W-1:0] row_length,
  output logic                           char_valid,
  input  wire logic                      char_stall,
  output logic [7:0]                     out_char,
  output logic                           last_of_burst
);

  localparam int unsigned NW = $clog2(MAX_COLS + 1);
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned FW = 2 + 2 * (NW + rle_pkg::SYM_W);

  logic          push;
  logic [FW-1:0] push_data;
  logic          pop;
  logic [FW-1:0] pop_data;
  logic          fifo_full;
  logic          fifo_empty;

  assign cfg_ready = 1'b1;

  rle_front #(
    .MAX_COLS (MAX_COLS),
    .NW       (NW),
    .CW       (CW),
    .FW       (FW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_value (cell_value),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (row_length),
    .push       (push),
    .push_data  (push_data),
    .fifo_full  (fifo_full)
  );

  rle_cmd_fifo #(
    .WIDTH (FW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  rle_back #(
    .NW (NW),
    .FW (FW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .fifo_empty    (fifo_empty),
    .fifo_data     (pop_data),
    .pop           (pop),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .out_char      (out_char),
    .last_of_burst (last_of_burst)
  );

endmodule

`default_nettype wire

FILE: test/rle_row_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_row_encoder_tb
// Self-checking bench for the run-length row encoder. Cells are fed through
// the valid/stall input channel and every emitted character is compared
// with the directed table's text or a software encoder kept in step with the
// block. The run starts with a short table of directed cells and row lengths,
// then random phases under several row lengths, including an over-range width.
// ----------------------------------------------------------------------------

module rle_row_encoder_tb;

  localparam int unsigned MAX_COLS       = 4096;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PHASE_CELLS    = 40;
  localparam int          NUM_PHASES     = 11;
  localparam int          CALM_PHASE     = 3;
  localparam int          HOLD_PHASE     = 1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef enum logic {STEP_CFG, STEP_CELL} step_kind_t;

  // One row of the directed table. Where typed is set, the expected text is
  // given in text (first character most significant) with n characters.
  typedef struct packed {
    step_kind_t  kind;
    logic [12:0] value;
    logic        typed;
    logic [3:0]  n;
    logic [87:0] text;
  } step_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cell_valid = 1'b0;
  logic                      cell_stall;
  logic [7:0]                cell_value = 8'd0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [rle_pkg::CFG_W-1:0] row_length = '0;
  logic                      char_valid;
  logic                      char_stall = 1'b0;
  logic [7:0]                out_char;
  logic                      last_of_burst;

  // Encoder shadow state.
  logic [12:0]       row_len_cfg = rle_pkg::ROW_LENGTH_RESET;
  logic [7:0]        cur_sym = 8'd0;
  int unsigned       cur_count = 0;
  int unsigned       cur_col = 0;

  text_char_t        burst[$];
  text_char_t        pending_text[$];
  int                err_count = 0;
  int                chars_seen = 0;
  int                quiet_cycles = 0;
  bit                calm = 1'b0;
  bit                hold_req = 1'b0;

  step_t dir_steps [0:36] = '{
    '{STEP_CFG,  13'd1,   1'b0, 4'd0, '0},
    '{STEP_CELL, 13'h00,  1'b1, 4'd3, {"1", 8'h00, "\n"}},
    '{STEP_CELL, 13'hFF,  1'b1, 4'd3, {"1", 8'hFF, "\n"}},
    '{STEP_CFG,  13'd0,   1'b0, 4'd0, '0},
    '{STEP_CELL, "A",     1'b1, 4'd3, "1A\n"},
    '{STEP_CFG,  13'd3,   1'b0, 4'd0, '0},
    '{STEP_CELL, "a",     1'b1, 4'd0, '0},
    '{STEP_CELL, "a",     1'b1, 4'd0, '0},
    '{STEP_CELL, "b",     1'b1, 4'd5, "2a1b\n"},
    '{STEP_CELL, "x",     1'b0, 4'd0, '0},
    '{STEP_CELL, "y",     1'b0, 4'd0, '0},
    '{STEP_CELL, "z",     1'b0, 4'd0, '0},
    '{STEP_CFG,  13'd4,   1'b0, 4'd0, '0},
    '{STEP_CELL, "q",     1'b1, 4'd0, '0},
    '{STEP_CELL, "q",     1'b1, 4'd0, '0},
    '{STEP_CELL, "q",     1'b1, 4'd0, '0},
    '{STEP_CELL, "q",     1'b1, 4'd3, "4q\n"},
    '{STEP_CFG,  13'd10,  1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b0, 4'd0, '0},
    '{STEP_CELL, "k",     1'b1, 4'd4, "10k\n"},
    '{STEP_CFG,  13'd8,   1'b0, 4'd0, '0},
    '{STEP_CELL, "m",     1'b0, 4'd0, '0},
    '{STEP_CELL, "m",     1'b0, 4'd0, '0},
    '{STEP_CELL, "m",     1'b0, 4'd0, '0},
    // Shrinking the row below the current column ends the row at the next cell.
    '{STEP_CFG,  13'd2,   1'b0, 4'd0, '0},
    '{STEP_CELL, "m",     1'b1, 4'd3, "4m\n"},
    '{STEP_CELL, "n",     1'b0, 4'd0, '0},
    '{STEP_CELL, "p",     1'b0, 4'd0, '0},
    '{STEP_CFG,  13'd8191, 1'b0, 4'd0, '0}
  };

  logic [12:0] phase_len [0:NUM_PHASES-1] = '{
    13'd5, 13'd16, 13'd2, 13'd100, 13'd4096, 13'd7, 13'd33, 13'd1, 13'd8191,
    13'd64, 13'd3
  };

  rle_row_encoder #(
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_value   (cell_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .row_length   (row_length),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .out_char     (out_char),
    .last_of_burst(last_of_burst)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    err_count++;
  endtask

  // Appends the decimal count and the symbol of one finished run.
  function automatic void emit_run(input int unsigned count, input logic [7:0] sym);
    logic [7:0]  digits[$];
    int unsigned c;
    c = count;
    while (c != 0) begin
      digits.push_front(rle_pkg::ASCII_ZERO + 8'(c % 10));
      c = c / 10;
    end
    foreach (digits[i]) burst.push_back(text_char_t'{digits[i], 1'b0});
    burst.push_back(text_char_t'{sym, 1'b0});
  endfunction

  function automatic void encode_cell(input logic [7:0] cell_in);
    int unsigned eff_len;
    eff_len = row_len_cfg;
    if (eff_len == 0) eff_len = 1;
    if (eff_len > MAX_COLS) eff_len = MAX_COLS;
    burst.delete();
    if (cur_col == 0) begin
      cur_sym = cell_in;
      cur_count = 1;
    end else if (cell_in != cur_sym) begin
      emit_run(cur_count, cur_sym);
      cur_sym = cell_in;
      cur_count = 1;
    end else begin
      cur_count++;
    end
    if (cur_col + 1 >= eff_len) begin
      emit_run(cur_count, cur_sym);
      burst.push_back(text_char_t'{rle_pkg::ASCII_NL, 1'b0});
      cur_sym = 8'd0;
      cur_count = 0;
      cur_col = 0;
    end else begin
      cur_col++;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
  endfunction

  // Offers one cell, holding it until taken, then queues the expected text.
  task automatic send_cell(input logic [7:0] v, input logic typed, input int n,
                           input logic [87:0] text);
    while (!calm && $urandom_range(99) < 24) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_value <= v;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    encode_cell(v);
    if (typed) begin
      for (int j = 0; j < n; j++)
        pending_text.push_back(text_char_t'{text[8*(n-1-j) +: 8], j == n - 1});
    end else begin
      foreach (burst[i]) pending_text.push_back(burst[i]);
    end
  endtask

  task automatic wait_drained();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_length(input logic [12:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    row_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    row_len_cfg = v;
  endtask

  initial begin : stimulus
    logic [7:0] v;
    logic [7:0] prev;
    logic [7:0] pool [0:2];
    int         rep_pct;
    int         r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG)
        write_row_length(dir_steps[i].value);
      else
        send_cell(dir_steps[i].value[7:0], dir_steps[i].typed, dir_steps[i].n,
                  dir_steps[i].text);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_row_length(phase_len[p]);
      calm = (p == CALM_PHASE);
      if (phase_len[p] == 13'd8191) begin
        // The width is clamped; one symbol keeps a single long run open.
        v = 8'($urandom_range(255));
        for (int k = 0; k < PHASE_CELLS; k++) send_cell(v, 1'b0, 0, '0);
      end else begin
        foreach (pool[j]) pool[j] = 8'($urandom_range(255));
        rep_pct = (phase_len[p] >= 13'd100) ? 92 : 55;
        prev = pool[0];
        for (int k = 0; k < PHASE_CELLS; k++) begin
          if (p == HOLD_PHASE && k == 5) hold_req = 1'b1;
          r = $urandom_range(99);
          if (r < 10) v = 8'($urandom_range(255));
          else if (r < rep_pct) v = prev;
          else v = pool[$urandom_range(2)];
          send_cell(v, 1'b0, 0, '0);
          prev = v;
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    if (err_count == 0)
      $display("rle_row_encoder: match");
    else
      $display("rle_row_encoder: mismatch");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so the input backs up.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        char_stall <= 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        char_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && char_valid && !char_stall) begin
      chars_seen++;
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("char %0d: unexpected 0x%02h last=%0b",
                                  chars_seen, out_char, last_of_burst));
      end else begin
        want = pending_text.pop_front();
        if (out_char !== want.ch)
          report_mismatch($sformatf("char %0d: out_char 0x%02h, want 0x%02h",
                                    chars_seen, out_char, want.ch));
        if (last_of_burst !== want.last)
          report_mismatch($sformatf("char %0d: last_of_burst %0b, want %0b",
                                    chars_seen, last_of_burst, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_valid && !cell_stall) || (char_valid && !char_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rle_row_encoder: mismatch");
      $finish;
    end
  end

endmodule
